FILE: rtl/tick_rtc_and_button_events_top_assert.svh
// Assertion macros shared by the RTL of the tick clock block.
// Both sample on the rising edge of clk and are switched off while rst_n is low.
`ifndef TICK_RTC_AND_BUTTON_EVENTS_TOP_ASSERT_SVH
`define TICK_RTC_AND_BUTTON_EVENTS_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTCE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rtce_pkg.sv
package rtce_pkg;

    // Button event codes as they appear on the result port.
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_A_SHORT = 3'd1,
        EV_B_SHORT = 3'd2,
        EV_C_SHORT = 3'd3,
        EV_C_LONG  = 3'd4
    } btn_event_t;

    // Configuration register indexes.
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_DEBOUNCE   = 2'd0;
    localparam cfg_index_t CFG_LONG_PRESS = 2'd1;

    localparam logic [15:0] DEBOUNCE_RESET   = 16'd5;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd100;
    localparam logic [15:0] HELD_MAX         = 16'hFFFF;

    localparam logic [6:0] CENTI_LAST  = 7'd99;
    localparam logic [5:0] SEC_LAST    = 6'd59;
    localparam logic [5:0] MIN_LAST    = 6'd59;
    localparam logic [4:0] HOUR_LAST   = 5'd23;
    localparam logic [3:0] MONTH_LAST  = 4'd11;

    // Time of day and date after one tick.
    typedef struct packed {
        logic       rolled;
        logic [6:0] centisecond;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [7:0] year;
    } cal_t;

    // One complete result item.
    typedef struct packed {
        btn_event_t evt;
        cal_t       cal;
    } result_t;

    // Days in a month, no leap years. Codes above December count as 31 days.
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd1:    len = 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Held counter increment that stops at full scale.
    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == HELD_MAX) ? v : v + 16'd1;
    endfunction

endpackage

FILE: rtl/tick_rtc_and_button_events_top.sv
// The result item of an accepted tick is registered in the output buffer.
// Throughput: one tick per cycle while in_ready is high; the single-pass update of the counters sets this figure.
// A two-entry output buffer (result register plus skid register) keeps input ready high
// while one result is stalled at the output.
// Reset: rst_n is asynchronous and active low; it clears clock, counters, inhibit and
// valid flags, and loads the debounce and long-press registers with 5 and 100.
`include "tick_rtc_and_button_events_top_assert.svh"

module tick_rtc_and_button_events_top (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  rtce_pkg::cfg_index_t cfg_index,
    input  logic [15:0]          cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 level_a,
    input  logic                 level_b,
    input  logic                 level_c,
    input  logic                 menu_active,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           button_event,
    output logic                 second_rolled,
    output logic [6:0]           centisecond,
    output logic [5:0]           second,
    output logic [5:0]           minute,
    output logic [4:0]           hour,
    output logic [4:0]           day,
    output logic [3:0]           month,
    output logic [7:0]           year
);

    // Configuration registers. Writes must arrive only while the block is idle, a rule for the user
    // that the block itself does not enforce; the port is always ready. Indexes beyond the register list are ignored.
    logic [15:0] debounce_reg;
    logic [15:0] long_press_reg;
    logic        cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= rtce_pkg::DEBOUNCE_RESET;
            long_press_reg <= rtce_pkg::LONG_PRESS_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                rtce_pkg::CFG_DEBOUNCE:   debounce_reg   <= cfg_data;
                rtce_pkg::CFG_LONG_PRESS: long_press_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // Each accepted item is one tick. Both state units step on the handshake and
    // present the post-tick values combinationally for capture in the output buffer.
    logic                 in_fire;
    logic                 out_fire;
    rtce_pkg::btn_event_t evt;
    rtce_pkg::cal_t       cal;
    rtce_pkg::result_t    result_new;

    assign in_fire  = in_valid & in_ready;

    rtce_buttons u_buttons (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (in_fire),
        .level_a          (level_a),
        .level_b          (level_b),
        .level_c          (level_c),
        .menu_active      (menu_active),
        .debounce_ticks   (debounce_reg),
        .long_press_ticks (long_press_reg),
        .evt              (evt)
    );

    rtce_calendar u_calendar (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (in_fire),
        .cal   (cal)
    );

    assign result_new.evt = evt;
    assign result_new.cal = cal;

    // Output buffer. The result register drives the port; the skid register catches
    // an item that arrives while the result register is stalled. Input is ready
    // whenever the skid register is free, so one item can still be taken while the result register is stalled.
    rtce_pkg::result_t out_reg;
    rtce_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_fire  = out_valid_reg & out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_fire)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else if (!in_fire)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (in_fire)
            begin
                if (out_valid_reg)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers follow the same choices and need no reset.
    always_ff @(posedge clk)
    begin
        if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire)
            begin
                out_reg <= result_new;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg)
            begin
                skid_reg <= result_new;
            end
            else
            begin
                out_reg <= result_new;
            end
        end
    end

    assign button_event  = out_reg.evt;
    assign second_rolled = out_reg.cal.rolled;
    assign centisecond   = out_reg.cal.centisecond;
    assign second        = out_reg.cal.second;
    assign minute        = out_reg.cal.minute;
    assign hour          = out_reg.cal.hour;
    assign day           = out_reg.cal.day;
    assign month         = out_reg.cal.month;
    assign year          = out_reg.cal.year;

    // The skid register is only ever filled behind a waiting result.
    `RTCE_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with output empty")
    // An item taken into an empty buffer lands in the result register.
    `RTCE_ASSERT_NEXT(a_empty_fill, in_fire && !out_valid_reg, out_valid_reg && !skid_valid_reg, "item not placed in result register")
    // An item taken behind a stalled result lands in the skid register.
    `RTCE_ASSERT_NEXT(a_stall_to_skid, in_fire && out_valid_reg && !out_ready, skid_valid_reg, "item lost behind stalled result")
    // A new second always starts at centisecond zero.
    `RTCE_ASSERT_SAME(a_roll_at_zero, out_valid_reg && out_reg.cal.rolled, out_reg.cal.centisecond == 7'd0, "second rolled with nonzero centisecond")

endmodule

FILE: rtl/rtce_buttons.sv
module rtce_buttons (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  level_a,
    input  logic                  level_b,
    input  logic                  level_c,
    input  logic                  menu_active,
    input  logic [15:0]           debounce_ticks,
    input  logic [15:0]           long_press_ticks,
    output rtce_pkg::btn_event_t  evt
);

    logic [15:0] held_a_reg, held_a_next;
    logic [15:0] held_b_reg, held_b_next;
    logic [15:0] held_c_reg, held_c_next;
    logic        inhibit_reg, inhibit_next;
    logic        press_a, press_b, press_c;
    logic [15:0] held_c_inc;

    assign press_a    = menu_active & ~level_a;
    assign press_b    = menu_active & ~level_b;
    assign press_c    = ~level_c;
    assign held_c_inc = rtce_pkg::sat_inc(held_c_reg);

    always_comb
    begin
        evt          = rtce_pkg::EV_NONE;
        inhibit_next = inhibit_reg;
        held_c_next  = 16'd0;

        // Button C: count while held and fire short on release, or fire long once and then wait for release.
        if (press_c && !inhibit_reg)
        begin
            held_c_next = held_c_inc;
            if (held_c_inc >= long_press_ticks)
            begin
                inhibit_next = 1'b1;
            end
        end
        else
        begin
            if (!press_c)
            begin
                inhibit_next = 1'b0;
            end
            if (held_c_reg < debounce_ticks)
            begin
                evt = rtce_pkg::EV_NONE;
            end
            else if (held_c_reg < long_press_ticks)
            begin
                evt = rtce_pkg::EV_C_SHORT;
            end
            else
            begin
                evt = rtce_pkg::EV_C_LONG;
            end
        end

        // Buttons A and B fire on release, or when the menu closes under them.
        if (press_a)
        begin
            held_a_next = rtce_pkg::sat_inc(held_a_reg);
        end
        else
        begin
            held_a_next = 16'd0;
            if (held_a_reg >= debounce_ticks)
            begin
                evt = rtce_pkg::EV_A_SHORT;
            end
        end

        if (press_b)
        begin
            held_b_next = rtce_pkg::sat_inc(held_b_reg);
        end
        else
        begin
            held_b_next = 16'd0;
            if (held_b_reg >= debounce_ticks)
            begin
                evt = rtce_pkg::EV_B_SHORT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_a_reg  <= 16'd0;
            held_b_reg  <= 16'd0;
            held_c_reg  <= 16'd0;
            inhibit_reg <= 1'b0;
        end
        else if (step)
        begin
            held_a_reg  <= held_a_next;
            held_b_reg  <= held_b_next;
            held_c_reg  <= held_c_next;
            inhibit_reg <= inhibit_next;
        end
    end

endmodule

FILE: rtl/rtce_calendar.sv
module rtce_calendar (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    output rtce_pkg::cal_t  cal
);

    rtce_pkg::cal_t cal_reg;
    rtce_pkg::cal_t cal_next;
    logic [5:0]     day_plus;

    assign day_plus = {1'b0, cal_reg.day} + 6'd1;

    always_comb
    begin
        cal_next        = cal_reg;
        cal_next.rolled = 1'b0;
        if (cal_reg.centisecond < rtce_pkg::CENTI_LAST)
        begin
            cal_next.centisecond = cal_reg.centisecond + 7'd1;
        end
        else
        begin
            cal_next.centisecond = 7'd0;
            cal_next.rolled      = 1'b1;
            if (cal_reg.second < rtce_pkg::SEC_LAST)
            begin
                cal_next.second = cal_reg.second + 6'd1;
            end
            else
            begin
                cal_next.second = 6'd0;
                if (cal_reg.minute < rtce_pkg::MIN_LAST)
                begin
                    cal_next.minute = cal_reg.minute + 6'd1;
                end
                else
                begin
                    cal_next.minute = 6'd0;
                    if (cal_reg.hour < rtce_pkg::HOUR_LAST)
                    begin
                        cal_next.hour = cal_reg.hour + 5'd1;
                    end
                    else
                    begin
                        cal_next.hour = 5'd0;
                        if (day_plus < {1'b0, rtce_pkg::month_len(cal_reg.month)})
                        begin
                            cal_next.day = day_plus[4:0];
                        end
                        else
                        begin
                            cal_next.day = 5'd0;
                            if (cal_reg.month < rtce_pkg::MONTH_LAST)
                            begin
                                cal_next.month = cal_reg.month + 4'd1;
                            end
                            else
                            begin
                                cal_next.month = 4'd0;
                                cal_next.year  = cal_reg.year + 8'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (step)
        begin
            cal_reg <= cal_next;
        end
    end

    assign cal = cal_next;

endmodule
